// File: rtl/core/ilid_pkg.sv
// Shared operation codes, status codes and limits for the indexed list.
package ilid_pkg;

  // Operation codes carried by the operation field.
  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_READ    = 3'd2,
    OP_DELETE  = 3'd3,
    OP_REPLACE = 3'd4,
    OP_DUMP    = 3'd5
  } op_t;

  // Status codes reported with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // A dump emits at most this many results.
  localparam int MAX_RESULTS = 16;

endpackage

// File: rtl/core/indexed_list_insert_delete.sv
// Fixed-capacity ordered list of words held in one RAM, with shift by sequencer.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_ready   operation, position, word_in
//   output   out        out_valid / out_ready status, word_out, count, last
//
// Append, replace, errors, an insert at the end and a delete of the last entry
// finish on acceptance. A read loads RAM data in S_READ; a dump reads each entry
// in S_DUMP_RD, captures it in S_DUMP_CAP. Insert and delete move one entry per
// S_MV_RD/S_MV_WR pass on the single RAM port pair, then S_FIN writes an insert.
// Reset clears the state, entry count and output valid; RAM contents stay unknown.
// A stalled output holds a dump in S_DUMP_CAP; input is taken only when idle.
module indexed_list_insert_delete #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           operation,
  input  logic [3:0]           position,
  input  logic [31:0]          word_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ilid_pkg::status_t    status,
  output logic [31:0]          word_out,
  output logic [4:0]           count,
  output logic                 last
);

  import ilid_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DUMP_RD,
    S_DUMP_CAP,
    S_MV_RD,
    S_MV_WR,
    S_FIN
  } state_t;

  state_t               state;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        fill_next;
  logic [AW-1:0]        src;
  logic [AW-1:0]        dst;
  logic [AW-1:0]        stop;
  logic                 shift_up;
  logic [AW-1:0]        dump_idx;
  logic [AW-1:0]        pos_hold;
  logic [WORD_BITS-1:0] word_hold;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 out_set;
  logic [WORD_BITS-1:0] word_w;
  logic [CMPW-1:0]      f_x;
  logic [CMPW-1:0]      p_x;
  logic [CMPW-1:0]      cap_x;
  logic [CMPW-1:0]      dump_n;
  logic                 dump_last;
  status_t              dec_status;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_accept = in_valid && in_ready;
  assign word_w    = WORD_BITS'(word_in);
  assign f_x       = CMPW'(fill);
  assign p_x       = CMPW'(position);
  assign cap_x     = CMPW'(CAPACITY);
  assign dump_n    = (f_x < CMPW'(MAX_RESULTS)) ? f_x : CMPW'(MAX_RESULTS);
  assign dump_last = (CMPW'(dump_idx) + CMPW'(1)) == dump_n;

  // Decode the status of the offered transaction and the count it leaves.
  always_comb begin
    dec_status = ST_OK;
    fill_next  = fill;
    case (operation) inside
      OP_APPEND: begin
        if (f_x >= cap_x) begin
          dec_status = ST_FULL;
        end else begin
          fill_next = fill + CW'(1);
        end
      end
      OP_INSERT: begin
        if (p_x >= cap_x || p_x > f_x) begin
          dec_status = ST_RANGE;
        end else if (f_x >= cap_x) begin
          dec_status = ST_FULL;
        end else begin
          fill_next = fill + CW'(1);
        end
      end
      OP_READ, OP_DELETE, OP_REPLACE: begin
        if (fill == '0) begin
          dec_status = ST_EMPTY;
        end else if (p_x >= f_x) begin
          dec_status = ST_RANGE;
        end else if (operation == OP_DELETE) begin
          fill_next = fill - CW'(1);
        end
      end
      OP_DUMP: begin
        if (fill == '0) begin
          dec_status = ST_EMPTY;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // A read or a non-empty dump delivers its result later from RAM data.
  assign out_load = in_accept && !(dec_status == ST_OK &&
                    (operation == OP_READ || operation == OP_DUMP));

  // A new result enters the output register in this cycle.
  assign out_set = out_load || (state == S_READ) || (state == S_DUMP_CAP && out_free);

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = src;
    unique case (state)
      S_IDLE: begin
        if (in_accept && dec_status == ST_OK) begin
          if (operation == OP_APPEND) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(fill);
            ram_wdata = word_w;
          end else if ((operation == OP_INSERT && p_x == f_x) ||
                       operation == OP_REPLACE) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(position);
            ram_wdata = word_w;
          end else if (operation == OP_READ) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(position);
          end
        end
      end
      S_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = dump_idx;
      end
      S_MV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = src;
      end
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dst;
        ram_wdata = ram_rdata;
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = pos_hold;
        ram_wdata = word_hold;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ilid_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer state, entry count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output valid rises when a result is loaded and falls when it is taken.
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            fill      <= fill_next;
            pos_hold  <= AW'(position);
            word_hold <= word_w;
            if (out_load) begin
              status    <= dec_status;
              word_out  <= '0;
              count     <= 5'(fill_next);
              last      <= 1'b1;
            end
            if (dec_status == ST_OK) begin
              if (operation == OP_READ) begin
                state <= S_READ;
              end else if (operation == OP_DUMP) begin
                dump_idx <= '0;
                state    <= S_DUMP_RD;
              end else if (operation == OP_INSERT && p_x != f_x) begin
                src      <= AW'(f_x - CMPW'(1));
                dst      <= AW'(fill);
                stop     <= AW'(position);
                shift_up <= 1'b1;
                state    <= S_MV_RD;
              end else if (operation == OP_DELETE && (p_x + CMPW'(1)) != f_x) begin
                src      <= AW'(p_x + CMPW'(1));
                dst      <= AW'(position);
                stop     <= AW'(f_x - CMPW'(1));
                shift_up <= 1'b0;
                state    <= S_MV_RD;
              end
            end
          end
        end
        S_READ: begin
          status    <= ST_OK;
          word_out  <= 32'(ram_rdata);
          count     <= 5'(fill);
          last      <= 1'b1;
          state     <= S_IDLE;
        end
        S_DUMP_RD: begin
          state <= S_DUMP_CAP;
        end
        S_DUMP_CAP: begin
          if (out_free) begin
            status    <= ST_OK;
            word_out  <= 32'(ram_rdata);
            count     <= 5'(fill);
            last      <= dump_last;
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              dump_idx <= dump_idx + AW'(1);
              state    <= S_DUMP_RD;
            end
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          if (src == stop) begin
            state <= shift_up ? S_FIN : S_IDLE;
          end else begin
            if (shift_up) begin
              src <= src - AW'(1);
              dst <= dst - AW'(1);
            end else begin
              src <= src + AW'(1);
              dst <= dst + AW'(1);
            end
            state <= S_MV_RD;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The list never holds more entries than its capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(fill) <= CMPW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The count changes only in the cycle a transaction is taken.
  a_fill_stable: assert property (@(posedge clk) disable iff (rst)
    !$past(in_accept) |-> $stable(fill))
    else $error("entry count changed outside an accepted transaction");

  // RAM writes come only from an accepted transaction or the shift sequencer.
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_IDLE && in_accept) || state == S_MV_WR || state == S_FIN))
    else $error("unexpected RAM write");

  // The final dump result returns the sequencer to idle.
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_CAP && out_free && dump_last) |=> (state == S_IDLE && last))
    else $error("dump did not finish after its last result");

endmodule

// File: rtl/core/ilid_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: test/tb_indexed_list_insert_delete.sv
// Self-checking testbench for the indexed list block, with scoreboard and random traffic.
module tb_indexed_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import ilid_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // One expected output transaction.
  typedef struct packed {
    status_t     status;
    logic [31:0] word;
    logic [4:0]  count;
    logic        last;
  } list_result_t;

  // Scoreboard: shadow copy of the list plus the queue of awaited results.
  class list_scoreboard;
    logic [31:0]  slots [LIST_DEPTH];
    int unsigned  held;
    list_result_t awaited [$];
    int           fails;

    function new();
      held = 0;
      fails = 0;
    endfunction

    function void report(string msg);
      // Keep the log short when the block is badly broken.
      if (fails < 100) begin
        $display("ERROR at %0t ns: %s", $time, msg);
      end
      fails++;
    endfunction

    function void expect_one(status_t st, logic [31:0] w, logic lst);
      list_result_t r;
      r.status = st;
      r.word = w;
      r.count = held[4:0];
      r.last = lst;
      awaited.push_back(r);
    endfunction

    // Apply one accepted operation to the shadow list and queue its results.
    function void note_op(logic [2:0] op, logic [3:0] pos, logic [31:0] w);
      status_t     st;
      logic [31:0] rd;
      int unsigned n;
      st = ST_OK;
      rd = '0;
      case (op)
        OP_APPEND: begin
          if (held >= LIST_DEPTH) begin
            st = ST_FULL;
          end else begin
            slots[held] = w;
            held++;
          end
        end
        OP_INSERT: begin
          if (pos >= LIST_DEPTH || pos > held) begin
            st = ST_RANGE;
          end else if (held >= LIST_DEPTH) begin
            st = ST_FULL;
          end else begin
            for (int i = held; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = w;
            held++;
          end
        end
        OP_READ, OP_DELETE, OP_REPLACE: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else if (pos >= held) begin
            st = ST_RANGE;
          end else if (op == OP_READ) begin
            rd = slots[pos];
          end else if (op == OP_DELETE) begin
            for (int i = pos; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
          end else begin
            slots[pos] = w;
          end
        end
        OP_DUMP: begin
          if (held == 0) begin
            st = ST_EMPTY;
          end else begin
            n = (held < MAX_RESULTS) ? held : MAX_RESULTS;
            for (int i = 0; i < n; i++) expect_one(ST_OK, slots[i], i + 1 == n);
            return;
          end
        end
        default: begin
          // Spare codes answer with a plain ok and change nothing.
        end
      endcase
      expect_one(st, rd, 1'b1);
    endfunction

    // Compare one output transaction with the oldest expectation.
    function void check_result(status_t st, logic [31:0] w, logic [4:0] c, logic lst);
      list_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d word %h count %0d",
                         st, w, c));
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) report($sformatf("status got %0d want %0d", st, e.status));
      if (w !== e.word) report($sformatf("word_out got %h want %h", w, e.word));
      if (c !== e.count) report($sformatf("count got %0d want %0d", c, e.count));
      if (lst !== e.last) report($sformatf("last got %0d want %0d", lst, e.last));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [3:0]  position = '0;
  logic [31:0] word_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  status_t     status;
  logic [31:0] word_out;
  logic [4:0]  count;
  logic        last;

  bit             burst = 1'b0;
  list_scoreboard sb = new();

  indexed_list_insert_delete dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .position  (position),
    .word_in   (word_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .word_out  (word_out),
    .count     (count),
    .last      (last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic issue_op(logic [2:0] op, logic [3:0] pos, logic [31:0] w);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    position <= pos;
    word_in <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pick an operation, leaning toward growth when the list is short.
  function automatic logic [2:0] pick_op(int unsigned held);
    int r;
    int grow;
    r = $urandom_range(0, 99);
    if (r < 2) return ($urandom_range(0, 1) != 0) ? OP_SPARE7 : OP_SPARE6;
    if (r < 9) return OP_DUMP;
    grow = (held <= 4) ? 60 : (held >= 13) ? 25 : 40;
    r = $urandom_range(0, 99);
    if (r < grow) return ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_READ;
    if (r < 65) return OP_REPLACE;
    return OP_DELETE;
  endfunction

  // Mostly legal positions, sometimes anything the field holds.
  function automatic logic [3:0] pick_pos(logic [2:0] op, int unsigned held);
    int unsigned top;
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(0, 15));
    if (op == OP_INSERT) begin
      top = (held > 15) ? 15 : held;
      return 4'($urandom_range(0, top));
    end
    if (held == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, held - 1));
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Output side: ready runs broken by stalls, including long steady stretches.
  initial begin : ready_driver
    int n;
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Transaction monitor: inputs are noted before outputs of the same edge are checked.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_op(operation, position, word_in);
    if (!rst && out_valid && out_ready) sb.check_result(status, word_out, count, last);
  end

  // Stimulus: directed corner cases, then random traffic, then drain.
  initial begin : stimulus
    logic [2:0] op;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list errors, insert past the end, insert at the head, append, a bad read, spare codes.
    issue_op(OP_DUMP, 4'd0, '0);
    issue_op(OP_READ, 4'd0, '0);
    issue_op(OP_DELETE, 4'd0, '0);
    issue_op(OP_REPLACE, 4'd0, 32'h5);
    issue_op(OP_INSERT, 4'd1, 32'h1234_5678);
    issue_op(OP_INSERT, 4'd0, 32'hFFFF_FFFF);
    issue_op(OP_APPEND, 4'd0, 32'h0);
    issue_op(OP_READ, 4'd5, '0);
    issue_op(OP_SPARE6, 4'd15, 32'hFFFF_FFFF);
    issue_op(OP_SPARE7, 4'd0, '0);

    // Fill to capacity, then hit the full cases and dump everything.
    for (int k = 0; k < LIST_DEPTH - 2; k++) begin
      issue_op(OP_APPEND, 4'(k), (32'h1 << (2 * k)) | 32'(k));
    end
    issue_op(OP_APPEND, 4'd0, 32'hDEAD_BEEF);
    issue_op(OP_INSERT, 4'd3, 32'hCAFE_0000);
    issue_op(OP_READ, 4'd15, '0);
    issue_op(OP_DUMP, 4'd0, '0);
    issue_op(OP_DELETE, 4'd15, '0);
    issue_op(OP_REPLACE, 4'd0, '0);
    issue_op(OP_READ, 4'd15, '0);

    // Random traffic with bursts and one full drain in the middle.
    for (int k = 0; k < 300; k++) begin
      if (k % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (k == 150) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      op = pick_op(sb.held);
      issue_op(op, pick_pos(op, sb.held), pick_word());
    end
    in_valid <= 1'b0;

    // Wait for every expected result, then watch for stray ones.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("indexed_list_insert_delete: match");
    end else begin
      $display("indexed_list_insert_delete: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #12_000_000;
    $display("indexed_list_insert_delete: mismatch");
    $finish;
  end

endmodule
